// ===== src/divisor_enumerator_core_defines.svh =====
// assertion macros used by the checker
`ifndef DIVISOR_ENUMERATOR_CORE_DEFINES_SVH
`define DIVISOR_ENUMERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define DVE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dve check failed");

// next-cycle implication
`define DVE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dve check failed");

`endif

// ===== src/dve_pkg.sv =====
`timescale 1ns / 1ps
package dve_pkg;

   localparam int DEF_NUM_BITS    = 12;
   localparam int DEF_STACK_DEPTH = 32;

   // fixed field widths
   localparam int NUMBER_WIDTH = 12;
   localparam int DATA_WIDTH   = 16;
   localparam int STACK_WIDTH  = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_TRIAL,
      ST_TRIAL_WAIT,
      ST_POP_READ,
      ST_POP_DIV,
      ST_POP_WAIT,
      ST_FLUSH
   } dve_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dve_div_status_type;

endpackage

// ===== src/dve_divider.sv =====
`timescale 1ns / 1ps
module dve_divider
   import dve_pkg::*;
#(
   parameter int NUM_BITS = DEF_NUM_BITS,
   parameter int DEN_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output dve_div_status_type  status,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder
);

   // four restoring steps per cycle
   localparam int STEPS  = 4;
   localparam int CYCLES = (NUM_BITS + STEPS - 1) / STEPS;
   localparam int PAD    = CYCLES * STEPS;
   localparam int CNT_BITS = $clog2(CYCLES + 1);

   logic [PAD-1:0]      work_ff, work_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                busy_ff, done_ff;
   logic [DEN_BITS:0]   part;

   // dividend bits leave at the top, quotient bits enter at the bottom
   always_comb begin
      part    = {1'b0, rem_ff};
      work_in = work_ff;
      for (int i = 0; i < STEPS; i++) begin
         part    = {part[DEN_BITS-1:0], work_in[PAD-1]};
         work_in = {work_in[PAD-2:0], 1'b0};
         if (part >= {1'b0, den_ff}) begin
            part       = part - {1'b0, den_ff};
            work_in[0] = 1'b1;
         end
      end
      rem_in = part[DEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= CNT_BITS'(CYCLES);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= PAD'(dividend);
         rem_ff  <= '0;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = work_ff[NUM_BITS-1:0];
   assign remainder   = rem_ff;

endmodule

// ===== src/divisor_enumerator_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   req_tdata[11:0] number
// rsp       out  rsp_tvalid/rsp_tready   rsp_tdata[11:0] divisor, rsp_tlast, rsp_tuser invalid
//
// a number is taken only when the sequencer is idle; zero gives one flagged word;
// each trial value needs a divider start, a divider run and a check, and each
// stored small divisor a stack read, a divider run and a check; trials and
// stack pops share the one 4-bit-per-cycle divider
// a stalled rsp side holds the sequencer once the result register and the
// one-word hold register are both full
// reset is synchronous; the stack memory needs no clearing
module divisor_enumerator_core
   import dve_pkg::*;
#(
   parameter int NUM_BITS    = DEF_NUM_BITS,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,  // [11:0] number
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,  // [11:0] divisor
   output logic                  rsp_tlast,
   output logic                  rsp_tuser   // [0] invalid
);

   localparam int TRIAL_BITS = (NUM_BITS + 1) / 2 + 1;
   localparam int SQ_BITS    = 2 * TRIAL_BITS;
   localparam int DEN_BITS   = (TRIAL_BITS > STACK_WIDTH) ? TRIAL_BITS : STACK_WIDTH;
   localparam int CMP_BITS   = (NUM_BITS > STACK_WIDTH) ? NUM_BITS : STACK_WIDTH;
   localparam int ADDR_BITS  = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS = $clog2(STACK_DEPTH + 1);

   dve_state_type state_ff, state_in;

   logic [NUM_BITS-1:0]    number_ff;
   logic [TRIAL_BITS-1:0]  trial_ff;
   logic [SQ_BITS-1:0]     square_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [STACK_WIDTH-1:0] rd_data_ff;
   logic                   pend_valid_ff;
   logic [NUM_BITS-1:0]    pend_value_ff;
   logic                   rsp_valid_ff;
   logic [NUM_BITS-1:0]    rsp_value_ff;
   logic                   rsp_last_ff, rsp_invalid_ff;

   logic [STACK_WIDTH-1:0] stack_mem [STACK_DEPTH];

   logic                req_accept, out_free, can_emit, over_root, stack_full;
   logic                div_start, trial_adv, emit_new, push, pop_read;
   logic                load_flush, load_zero;
   logic [NUM_BITS-1:0] emit_value;
   logic [DEN_BITS-1:0] div_divisor;
   logic [NUM_BITS-1:0] div_quotient;
   logic [DEN_BITS-1:0] div_remainder;
   dve_div_status_type  div_status;

   dve_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (DEN_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number_ff),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign can_emit   = !pend_valid_ff || out_free;
   assign over_root  = square_ff > SQ_BITS'(number_ff);
   assign stack_full = count_ff >= COUNT_BITS'(STACK_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tdata[NUM_BITS-1:0] == '0) ? ST_ZERO : ST_TRIAL;
            end
         end
         ST_ZERO: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_TRIAL: begin
            state_in = over_root ? ST_POP_READ : ST_TRIAL_WAIT;
         end
         ST_TRIAL_WAIT: begin
            if (div_status.done && (div_remainder != '0 || can_emit)) state_in = ST_TRIAL;
         end
         ST_POP_READ: begin
            state_in = (count_ff == '0) ? ST_FLUSH : ST_POP_DIV;
         end
         ST_POP_DIV: begin
            state_in = (rd_data_ff == '0) ? ST_POP_READ : ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            if (div_status.done &&
                (CMP_BITS'(div_quotient) == CMP_BITS'(rd_data_ff) || can_emit)) begin
               state_in = ST_POP_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_start   = 1'b0;
      div_divisor = DEN_BITS'(trial_ff);
      trial_adv   = 1'b0;
      emit_new    = 1'b0;
      emit_value  = NUM_BITS'(trial_ff);
      push        = 1'b0;
      pop_read    = 1'b0;
      load_flush  = 1'b0;
      load_zero   = 1'b0;
      case (state_ff)
         ST_ZERO: load_zero = out_free;
         ST_TRIAL: div_start = !over_root;
         ST_TRIAL_WAIT: begin
            if (div_status.done) begin
               if (div_remainder != '0) begin
                  trial_adv = 1'b1;
               end else if (can_emit) begin
                  trial_adv = 1'b1;
                  emit_new  = 1'b1;
                  push      = !stack_full;
               end
            end
         end
         ST_POP_READ: pop_read = (count_ff != '0);
         ST_POP_DIV: begin
            div_divisor = DEN_BITS'(rd_data_ff);
            div_start   = (rd_data_ff != '0);
         end
         ST_POP_WAIT: begin
            emit_value = div_quotient;
            emit_new   = div_status.done && can_emit &&
                         (CMP_BITS'(div_quotient) != CMP_BITS'(rd_data_ff));
         end
         ST_FLUSH: load_flush = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         trial_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            count_ff      <= '0;
            trial_ff      <= TRIAL_BITS'(1);
            pend_valid_ff <= 1'b0;
         end
         if (trial_adv) trial_ff <= trial_ff + 1'b1;
         if (push) count_ff <= count_ff + 1'b1;
         else if (pop_read) count_ff <= count_ff - 1'b1;
         if (emit_new) pend_valid_ff <= 1'b1;
         else if (load_flush) pend_valid_ff <= 1'b0;
         if (load_zero || load_flush || (emit_new && pend_valid_ff)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         number_ff <= req_tdata[NUM_BITS-1:0];
         square_ff <= SQ_BITS'(1);
      end
      // (j+1)^2 = j^2 + 2j + 1
      if (trial_adv) square_ff <= square_ff + SQ_BITS'({trial_ff, 1'b1});
      if (emit_new) pend_value_ff <= emit_value;
      if (load_zero) begin
         rsp_value_ff   <= '0;
         rsp_last_ff    <= 1'b1;
         rsp_invalid_ff <= 1'b1;
      end else if (load_flush) begin
         rsp_value_ff   <= pend_value_ff;
         rsp_last_ff    <= 1'b1;
         rsp_invalid_ff <= 1'b0;
      end else if (emit_new && pend_valid_ff) begin
         rsp_value_ff   <= pend_value_ff;
         rsp_last_ff    <= 1'b0;
         rsp_invalid_ff <= 1'b0;
      end
   end

   // small divisor stack
   always_ff @(posedge clock) begin
      if (push) stack_mem[count_ff[ADDR_BITS-1:0]] <= STACK_WIDTH'(trial_ff);
      if (pop_read) begin
         rd_data_ff <= stack_mem[ADDR_BITS'(count_ff - 1'b1)];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'(NUMBER_WIDTH'(rsp_value_ff));
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_invalid_ff;

endmodule

// ===== src/dve_checker.sv =====
`timescale 1ns / 1ps
`include "divisor_enumerator_core_defines.svh"
module dve_checker
   import dve_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [DATA_WIDTH-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_WIDTH-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   logic req_accept;
   assign req_accept = req_tvalid && req_tready && (req_tdata == req_tdata);

   // a stalled word holds
   `DVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // the invalid word is a lone zero that closes the number
   `DVE_ASSERT_NOW(a_invalid_form, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tlast && rsp_tdata == '0)

   // every real divisor is nonzero
   `DVE_ASSERT_NOW(a_divisor_nonzero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata != '0)

   // one number at a time
   `DVE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)

endmodule

bind divisor_enumerator_core dve_checker u_dve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
